>>> src/fasta_record_scanner_macros.svh
// ----------------------------------------------------------------------------
// FASTA record scanner assertion macros
// Shared concurrent assertion forms for the scanner, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FASTA_RECORD_SCANNER_MACROS_SVH
`define FASTA_RECORD_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> src/frs_pkg.sv
// ----------------------------------------------------------------------------
// FASTA record scanner package
// Character codes, phase encoding, counter control type and byte classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frs_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int BYTE_WIDTH      = 8;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOI  = 1'b1;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UC    = 8'h43;
  localparam logic [7:0] CHAR_UG    = 8'h47;
  localparam logic [7:0] CHAR_UT    = 8'h54;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LC    = 8'h63;
  localparam logic [7:0] CHAR_LG    = 8'h67;
  localparam logic [7:0] CHAR_LT    = 8'h74;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_NAME = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_SEQ  = 4'b1000
  } phase_t;

  // Per-cycle command to one record counter.
  typedef struct packed {
    logic clear;
    logic incr;
  } cnt_ctrl_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UA) && (c <= CHAR_UZ)) || ((c >= CHAR_LA) && (c <= CHAR_LZ));
  endfunction

  function automatic logic is_acgt(input logic [7:0] c);
    return (c == CHAR_UA) || (c == CHAR_LA) || (c == CHAR_UC) || (c == CHAR_LC) ||
           (c == CHAR_UG) || (c == CHAR_LG) || (c == CHAR_UT) || (c == CHAR_LT);
  endfunction

endpackage

>>> src/frs_sat_counter.sv
// ----------------------------------------------------------------------------
// FASTA record scanner saturating counter
// Clearable counter that sticks at its maximum and reports a value capped
// to the result field width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frs_sat_counter
  import frs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cnt_ctrl_t            ctrl,
  output logic [OUT_WIDTH-1:0] report
);

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.incr && (count != {COUNT_WIDTH{1'b1}})) begin
      count_next = count + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Values beyond the field range read as all ones.
  if (COUNT_WIDTH > OUT_WIDTH) begin : g_cap
    assign report = (|count[COUNT_WIDTH-1:OUT_WIDTH]) ? {OUT_WIDTH{1'b1}}
                                                      : count[OUT_WIDTH-1:0];
  end else if (COUNT_WIDTH < OUT_WIDTH) begin : g_ext
    assign report = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, count};
  end else begin : g_same
    assign report = count;
  end

endmodule

>>> src/fasta_record_scanner.sv
// ----------------------------------------------------------------------------
// FASTA record scanner
// Byte-per-request FASTA parser emitting header name bytes and per-record
// residue summaries.
// ----------------------------------------------------------------------------
// The scanner takes one request per clock cycle, each carrying either a file
// byte or an end-of-input marker, and sustains one request per cycle for any
// byte mix while results are accepted. A request sits in an input register
// while the phase register and the two record counters are updated, and any
// result is written into an output register, from which it is presented
// until accepted. The loop through the phase register and the counter
// incrementers sets that rate. The output register lets the next request be
// taken while a finished result still waits; the input stage only stalls
// when it holds a request that produces a result and the output register is
// full and not being drained. Bytes before the first '>' are dropped. A '>'
// outside a header closes any open record with a summary (kind 1: letters
// seen and letters other than A, C, G, T in either case) and opens a header;
// name bytes up to the first whitespace come out as kind 0 results, the rest
// of the header line is skipped, and the newline starts the sequence. The
// end-of-input marker summarizes any open record and returns to idle. Both
// counters saturate at 2^COUNT_WIDTH - 1 and are reported capped to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fasta_record_scanner
  import frs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  logic                  mode,
  input  logic [BYTE_WIDTH-1:0] byte_value,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  kind,
  output logic [BYTE_WIDTH-1:0] name_char,
  output logic [OUT_WIDTH-1:0]  seq_length,
  output logic [OUT_WIDTH-1:0]  other_count
);

`include "fasta_record_scanner_macros.svh"

  // Input register.
  logic                  s1_valid;
  logic                  s1_mode;
  logic [BYTE_WIDTH-1:0] s1_byte;

  // Parser state and result decode.
  phase_t                phase;
  phase_t                phase_next;
  logic                  res_valid;
  logic                  res_kind;
  logic [BYTE_WIDTH-1:0] res_char;
  cnt_ctrl_t             letter_ctrl;
  cnt_ctrl_t             other_ctrl;
  logic [OUT_WIDTH-1:0]  letter_report;
  logic [OUT_WIDTH-1:0]  other_report;

  logic out_free;
  logic s1_fire;
  logic s1_open;

  // The output register can load when it is empty or being drained.
  assign out_free   = !result_valid || result_ready;
  // A request with no result never waits on the output side.
  assign s1_fire    = s1_valid && (!res_valid || out_free);
  assign byte_ready = !s1_valid || s1_fire;

  // A '>' that opens a new record from idle or from a sequence.
  assign s1_open = s1_fire && (s1_mode == MODE_DATA) && (s1_byte == CHAR_GT) &&
                   ((phase == PH_IDLE) || (phase == PH_SEQ));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_mode <= mode;
      s1_byte <= byte_value;
    end
  end

  // Decode the held request against the current phase. Counter commands are
  // only issued when the request actually leaves the input register.
  always_comb begin
    logic clr;
    logic inc_letter;
    logic inc_other;
    clr        = 1'b0;
    inc_letter = 1'b0;
    inc_other  = 1'b0;
    phase_next = phase;
    res_valid  = 1'b0;
    res_kind   = KIND_SUMMARY;
    res_char   = '0;
    if (s1_mode == MODE_EOI) begin
      // End of input summarizes any open record, then everything resets.
      res_valid  = (phase != PH_IDLE);
      clr        = 1'b1;
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (s1_byte == CHAR_GT) begin
            clr        = 1'b1;
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          if (s1_byte == CHAR_NL) begin
            phase_next = PH_SEQ;
          end else if (is_space(s1_byte)) begin
            phase_next = PH_SKIP;
          end else begin
            res_valid = 1'b1;
            res_kind  = KIND_NAME;
            res_char  = s1_byte;
          end
        end
        PH_SKIP: begin
          if (s1_byte == CHAR_NL) begin
            phase_next = PH_SEQ;
          end
        end
        PH_SEQ: begin
          if (s1_byte == CHAR_GT) begin
            // Close the current record and open the next header.
            res_valid  = 1'b1;
            clr        = 1'b1;
            phase_next = PH_NAME;
          end else if (is_letter(s1_byte)) begin
            inc_letter = 1'b1;
            inc_other  = !is_acgt(s1_byte);
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    letter_ctrl.clear = s1_fire && clr;
    letter_ctrl.incr  = s1_fire && inc_letter;
    other_ctrl.clear  = s1_fire && clr;
    other_ctrl.incr   = s1_fire && inc_other;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (s1_fire) begin
      phase <= phase_next;
    end
  end

  frs_sat_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_letter_cnt (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (letter_ctrl),
    .report (letter_report)
  );

  frs_sat_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_other_cnt (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (other_ctrl),
    .report (other_report)
  );

  // Output register. A summary reads the counters before this cycle's clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && res_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      kind      <= res_kind;
      name_char <= res_char;
      if (res_kind == KIND_SUMMARY) begin
        seq_length  <= letter_report;
        other_count <= other_report;
      end else begin
        seq_length  <= '0;
        other_count <= '0;
      end
    end
  end

  // A summary never reports more odd letters than letters.
  `FRS_ASSERT_SAME(a_other_le_len, result_valid && (kind == KIND_SUMMARY), other_count <= seq_length)
  // Name characters are only produced while reading a header name.
  `FRS_ASSERT_SAME(a_name_in_name, s1_fire && res_valid && (res_kind == KIND_NAME), phase == PH_NAME)
  // End of input always leaves the parser idle.
  `FRS_ASSERT_NEXT(a_eoi_idle, s1_fire && (s1_mode == MODE_EOI), phase == PH_IDLE)
  // Opening a record starts both counters from zero.
  `FRS_ASSERT_NEXT(a_open_clears, s1_open, (letter_report == '0) && (other_report == '0))

endmodule
